// ===== hw/rtl/rdeg_pkg.sv =====
// Shared types and constants for the register dependency edge generator.
package rdeg_pkg;

  localparam int FUNC_W    = 3;
  localparam int REG_IN_W  = 8;
  localparam int OUT_IDX_W = 10;
  localparam int SPAN_W    = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LDI,
    FUNC_ASSIGN,
    FUNC_ADD,
    FUNC_SUB,
    FUNC_MUL,
    FUNC_DIV,
    FUNC_RET
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WR2,
    ST_ARITH,
    ST_RET
  } back_state_e;

endpackage

// ===== hw/rtl/rdeg_front.sv =====
// Front end: accepts instructions, numbers them, reduces registers, sizes return spans.
module rdeg_front import rdeg_pkg::*; #(
  parameter int NUM_VREGS  = 256,
  parameter int MAX_INSTRS = 1024,
  parameter int RET_SPAN   = 63,
  localparam int IW = $clog2(MAX_INSTRS),
  localparam int VW = $clog2(NUM_VREGS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [REG_IN_W-1:0] dst_reg_i,
  input  logic [REG_IN_W-1:0] src_reg_i,
  input  logic                src_present_i,
  input  logic                back_busy_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output logic [FUNC_W-1:0]   q_func_o,
  output logic [IW-1:0]       q_idx_o,
  output logic [VW-1:0]       q_dst_o,
  output logic [VW-1:0]       q_src_o,
  output logic                q_has2_o,
  output logic [IW-1:0]       q_start_o,
  output logic [SPAN_W-1:0]   q_count_o,
  output logic                q_ovf_o
);

  localparam int CW = IW + 8;
  localparam int RW = 20;
  localparam logic [RW-1:0] NV = RW'(NUM_VREGS);

  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] lr_q, lr_d;
  logic          lr_v_q, lr_v_d;
  logic          accept;
  logic [IW-1:0] start0;
  logic [CW-1:0] diff;
  logic [CW-1:0] back_st;
  logic          ovf;

  function automatic logic [VW-1:0] reduce(input logic [REG_IN_W-1:0] v);
    logic [RW-1:0] r;
    r = RW'(v);
    for (int k = REG_IN_W - 1; k >= 0; k--) begin
      if (r >= (NV << k)) r = r - (NV << k);
    end
    return VW'(r);
  endfunction

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] x);
    return (x == IW'(MAX_INSTRS - 1)) ? '0 : x + IW'(1);
  endfunction

  assign in_stall_o = back_busy_i || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = accept && (func_i <= FUNC_RET);

  always_comb begin
    start0  = lr_v_q ? inc(lr_q) : '0;
    diff    = CW'(cnt_q) - CW'(start0) + ((cnt_q < start0) ? CW'(MAX_INSTRS) : '0);
    ovf     = diff > CW'(RET_SPAN);
    back_st = CW'(cnt_q) - CW'(RET_SPAN)
              + ((CW'(cnt_q) < CW'(RET_SPAN)) ? CW'(MAX_INSTRS) : '0);
  end

  assign q_func_o  = func_i;
  assign q_idx_o   = cnt_q;
  assign q_dst_o   = reduce(dst_reg_i);
  assign q_src_o   = reduce(src_reg_i);
  assign q_has2_o  = src_present_i;
  assign q_start_o = ovf ? IW'(back_st) : start0;
  assign q_count_o = ovf ? SPAN_W'(RET_SPAN) : SPAN_W'(diff);
  assign q_ovf_o   = ovf;

  always_comb begin
    cnt_d  = cnt_q;
    lr_d   = lr_q;
    lr_v_d = lr_v_q;
    if (q_push_o) begin
      cnt_d = inc(cnt_q);
      if (func_e'(func_i) == FUNC_RET) begin
        lr_d   = cnt_q;
        lr_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      lr_q   <= '0;
      lr_v_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      lr_q   <= lr_d;
      lr_v_q <= lr_v_d;
    end
  end

endmodule

// ===== hw/rtl/rdeg_fifo.sv =====
// Two-entry queue between the front end and the back end.
module rdeg_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  input  logic         pop_i,
  output logic [W-1:0] dout_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, wp_d;
  logic         rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign dout_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/rdeg_back.sv =====
// Back end: writer/reader tables, clearing pass and edge emission sequencer.
module rdeg_back import rdeg_pkg::*; #(
  parameter int NUM_VREGS  = 256,
  parameter int MAX_INSTRS = 1024,
  localparam int IW = $clog2(MAX_INSTRS),
  localparam int VW = $clog2(NUM_VREGS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  output logic                 q_pop_o,
  input  logic [FUNC_W-1:0]    q_func_i,
  input  logic [IW-1:0]        q_idx_i,
  input  logic [VW-1:0]        q_dst_i,
  input  logic [VW-1:0]        q_src_i,
  input  logic                 q_has2_i,
  input  logic [IW-1:0]        q_start_i,
  input  logic [SPAN_W-1:0]    q_count_i,
  input  logic                 q_ovf_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_IDX_W-1:0] waiter_index_o,
  output logic [OUT_IDX_W-1:0] waited_on_index_o,
  output logic                 last_edge_o,
  output logic                 span_overflow_o
);

  back_state_e st_q, st_d;

  logic [IW:0] wr_mem [NUM_VREGS];
  logic [IW:0] rr_mem [NUM_VREGS];

  logic [VW-1:0]     clr_q, clr_d;
  logic [2:0]        pm_q, pm_d;
  logic              w1p_q, w1p_d;
  logic [SPAN_W-1:0] rem_q, rem_d;
  logic              ov_q, ov_d;

  func_e             func_q;
  logic [IW-1:0]     idx_q;
  logic [VW-1:0]     dst_q;
  logic [VW-1:0]     src_q;
  logic              has2_q;
  logic [IW-1:0]     j_q;
  logic              ovf_q;
  logic [IW:0]       w1_q, w2_q, r1_q;

  logic [OUT_IDX_W-1:0] o_waiter_q, o_pred_q;
  logic                 o_last_q, o_ovf_q;

  logic          wr_we, rr_we, rd_en;
  logic [VW-1:0] wr_wa, rr_wa;
  logic [IW:0]   wr_wd, rr_wd;

  logic          w1_v, r1_v, w2_v;
  logic [IW-1:0] w1_i, r1_i, w2_i;
  logic          e1, e2;
  logic [2:0]    mask_new;
  logic [2:0]    pm_nx;
  logic [IW-1:0] jn;
  logic          out_free;
  logic          emit, e_last;
  logic [IW-1:0] e_pred;
  logic          ret_w1, ret_j, ret_skip;

  assign w1_v = w1_q[IW];
  assign r1_v = r1_q[IW];
  assign w2_v = w2_q[IW] && has2_q;
  assign w1_i = w1_q[IW-1:0];
  assign r1_i = r1_q[IW-1:0];
  assign w2_i = w2_q[IW-1:0];

  assign e1 = r1_v && !(w1_v && OUT_IDX_W'(r1_i) == OUT_IDX_W'(w1_i));
  assign e2 = w2_v && !(w1_v && OUT_IDX_W'(w2_i) == OUT_IDX_W'(w1_i))
                   && !(e1 && OUT_IDX_W'(w2_i) == OUT_IDX_W'(r1_i));
  assign mask_new = (func_q == FUNC_LDI || func_q == FUNC_RET) ? 3'b000 : {e2, e1, w1_v};

  assign pm_nx    = pm_q & (pm_q - 3'd1);
  assign jn       = (j_q == IW'(MAX_INSTRS - 1)) ? '0 : j_q + IW'(1);
  assign out_free = !ov_q || !out_stall_i;
  assign busy_o   = st_q == ST_CLEAR;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_CLEAR: if (clr_q == VW'(NUM_VREGS - 1)) st_d = ST_IDLE;
      ST_IDLE:  if (!q_empty_i) st_d = ST_READ;
      ST_READ: begin
        case (func_q)
          FUNC_LDI: st_d = ST_IDLE;
          FUNC_RET: st_d = ST_RET;
          default:  st_d = ST_WR2;
        endcase
      end
      ST_WR2:   st_d = (pm_q != 3'b000) ? ST_ARITH : ST_IDLE;
      ST_ARITH: if (emit && e_last) st_d = ST_IDLE;
      ST_RET:   if ((emit && e_last) || (!w1p_q && rem_q == '0)) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    wr_we    = 1'b0;
    rr_we    = 1'b0;
    wr_wa    = dst_q;
    rr_wa    = dst_q;
    wr_wd    = {1'b1, idx_q};
    rr_wd    = {1'b1, idx_q};
    rd_en    = 1'b0;
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    e_last   = 1'b0;
    e_pred   = w1_i;
    ret_w1   = 1'b0;
    ret_j    = 1'b0;
    ret_skip = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        wr_we = 1'b1;
        rr_we = 1'b1;
        wr_wa = clr_q;
        rr_wa = clr_q;
        wr_wd = '0;
        rr_wd = '0;
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          rd_en   = 1'b1;
        end
      end
      ST_READ: begin
        wr_we = func_q != FUNC_RET;
        rr_we = func_q != FUNC_LDI && func_q != FUNC_ASSIGN;
      end
      ST_WR2: begin
        rr_we = has2_q;
        rr_wa = src_q;
      end
      ST_ARITH: begin
        if (out_free) begin
          emit   = 1'b1;
          e_last = pm_nx == 3'b000;
          if (pm_q[0]) e_pred = w1_i;
          else if (pm_q[1]) e_pred = r1_i;
          else e_pred = w2_i;
        end
      end
      ST_RET: begin
        if (w1p_q) begin
          if (out_free) begin
            emit   = 1'b1;
            ret_w1 = 1'b1;
            e_pred = w1_i;
            e_last = (rem_q == '0) || (rem_q == SPAN_W'(1) && j_q == w1_i);
          end
        end else if (rem_q != '0) begin
          if (w1_v && j_q == w1_i) begin
            ret_skip = 1'b1;
          end else if (out_free) begin
            emit   = 1'b1;
            ret_j  = 1'b1;
            e_pred = j_q;
            e_last = (rem_q == SPAN_W'(1)) || (rem_q == SPAN_W'(2) && w1_v && jn == w1_i);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    clr_d = clr_q;
    pm_d  = pm_q;
    w1p_d = w1p_q;
    rem_d = rem_q;
    ov_d  = ov_q;
    if (st_q == ST_CLEAR) clr_d = clr_q + VW'(1);
    if (q_pop_o) rem_d = q_count_i;
    if (st_q == ST_READ) begin
      pm_d  = mask_new;
      w1p_d = w1_v;
    end
    if (st_q == ST_ARITH && emit) pm_d = pm_nx;
    if (ret_w1) w1p_d = 1'b0;
    if (ret_j || ret_skip) rem_d = rem_q - SPAN_W'(1);
    if (emit) ov_d = 1'b1;
    else if (!out_stall_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_CLEAR;
      clr_q <= '0;
      pm_q  <= '0;
      w1p_q <= 1'b0;
      rem_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      pm_q  <= pm_d;
      w1p_q <= w1p_d;
      rem_q <= rem_d;
      ov_q  <= ov_d;
    end
  end

  // writer table: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_we) wr_mem[wr_wa] <= wr_wd;
    if (rd_en) begin
      w1_q <= wr_mem[q_dst_i];
      w2_q <= wr_mem[q_src_i];
    end
  end

  // reader table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (rr_we) rr_mem[rr_wa] <= rr_wd;
    if (rd_en) r1_q <= rr_mem[q_dst_i];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      func_q <= func_e'(q_func_i);
      idx_q  <= q_idx_i;
      dst_q  <= q_dst_i;
      src_q  <= q_src_i;
      has2_q <= q_has2_i;
      j_q    <= q_start_i;
      ovf_q  <= q_ovf_i;
    end else if (ret_j || ret_skip) begin
      j_q <= jn;
    end
    if (emit) begin
      o_waiter_q <= OUT_IDX_W'(idx_q);
      o_pred_q   <= OUT_IDX_W'(e_pred);
      o_last_q   <= e_last;
      o_ovf_q    <= (st_q == ST_RET) && ovf_q;
    end
  end

  assign out_valid_o       = ov_q;
  assign waiter_index_o    = o_waiter_q;
  assign waited_on_index_o = o_pred_q;
  assign last_edge_o       = o_last_q;
  assign span_overflow_o   = o_ovf_q;

endmodule

// ===== hw/rtl/register_dependency_edge_generator_top.sv =====
// Top level of the register dependency edge generator.
// Path to the first edge: the queue, the back-end states IDLE, READ, WR2 and ARITH for arithmetic
// or IDLE, READ and RET for a return, then the output register. The back end takes one beat at a
// time: a load immediate ends after READ, other arithmetic after WR2 or its edges in ARITH, a return
// after its edges and skipped slots in RET. A two-entry queue lets the front take beats meanwhile;
// unknown kinds are dropped. Reset: tables cleared one entry a cycle with the input stalled.
module register_dependency_edge_generator_top import rdeg_pkg::*; #(
  parameter int NUM_VREGS  = 256,
  parameter int MAX_INSTRS = 1024,
  parameter int RET_SPAN   = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [REG_IN_W-1:0]  dst_reg_i,
  input  logic [REG_IN_W-1:0]  src_reg_i,
  input  logic                 src_present_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_IDX_W-1:0] waiter_index_o,
  output logic [OUT_IDX_W-1:0] waited_on_index_o,
  output logic                 last_edge_o,
  output logic                 span_overflow_o
);

  localparam int IW = $clog2(MAX_INSTRS);
  localparam int VW = $clog2(NUM_VREGS);
  localparam int QW = FUNC_W + IW + VW + VW + 1 + IW + SPAN_W + 1;

  logic              back_busy, q_full, q_empty, q_push, q_pop;
  logic [QW-1:0]     q_din, q_dout;
  logic [FUNC_W-1:0] f_func, b_func;
  logic [IW-1:0]     f_idx, b_idx, f_start, b_start;
  logic [VW-1:0]     f_dst, b_dst, f_src, b_src;
  logic              f_has2, b_has2, f_ovf, b_ovf;
  logic [SPAN_W-1:0] f_count, b_count;

  rdeg_front #(
    .NUM_VREGS (NUM_VREGS),
    .MAX_INSTRS(MAX_INSTRS),
    .RET_SPAN  (RET_SPAN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .dst_reg_i    (dst_reg_i),
    .src_reg_i    (src_reg_i),
    .src_present_i(src_present_i),
    .back_busy_i  (back_busy),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_func_o     (f_func),
    .q_idx_o      (f_idx),
    .q_dst_o      (f_dst),
    .q_src_o      (f_src),
    .q_has2_o     (f_has2),
    .q_start_o    (f_start),
    .q_count_o    (f_count),
    .q_ovf_o      (f_ovf)
  );

  assign q_din = {f_func, f_idx, f_dst, f_src, f_has2, f_start, f_count, f_ovf};

  rdeg_fifo #(
    .W(QW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .din_i  (q_din),
    .pop_i  (q_pop),
    .dout_o (q_dout),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  assign {b_func, b_idx, b_dst, b_src, b_has2, b_start, b_count, b_ovf} = q_dout;

  rdeg_back #(
    .NUM_VREGS (NUM_VREGS),
    .MAX_INSTRS(MAX_INSTRS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .q_func_i         (b_func),
    .q_idx_i          (b_idx),
    .q_dst_i          (b_dst),
    .q_src_i          (b_src),
    .q_has2_i         (b_has2),
    .q_start_i        (b_start),
    .q_count_i        (b_count),
    .q_ovf_i          (b_ovf),
    .busy_o           (back_busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .waiter_index_o   (waiter_index_o),
    .waited_on_index_o(waited_on_index_o),
    .last_edge_o      (last_edge_o),
    .span_overflow_o  (span_overflow_o)
  );

endmodule
